FILE: rtl/drum_note_velocity_bar_meter_top_assert.svh
// ----------------------------------------------------------------------------
// drum note velocity bar meter assertion macros
// concurrent check helpers used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef DRUM_NOTE_VELOCITY_BAR_METER_TOP_ASSERT_SVH
`define DRUM_NOTE_VELOCITY_BAR_METER_TOP_ASSERT_SVH

// same-cycle implication
`define DNVB_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define DNVB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/dnvb_pkg.sv
// ----------------------------------------------------------------------------
// dnvb_pkg
// shared constants, types and functions of the drum note velocity bar meter
// ----------------------------------------------------------------------------
`default_nettype none

package dnvb_pkg;

    // ring size and bar scale
    localparam int NUM_BARS   = 64;
    localparam int FULL_WIDTH = 192;

    localparam int IDX_W   = $clog2(NUM_BARS);
    localparam int LEVEL_W = 7;
    localparam int WIDTH_W = 8;
    localparam int GROUP_W = 7;

    localparam logic [IDX_W-1:0]   LAST_SLOT  = IDX_W'(NUM_BARS - 1);
    localparam logic [GROUP_W-1:0] PASS_ALL   = 7'd127;
    localparam int                 LEVEL_MAX  = 127;
    localparam logic [LEVEL_W-1:0] DECAY_STEP = 7'd4;

    // floor(x / LEVEL_MAX) as (x * RECIP) >> DIV_SHIFT, exact for x < 2^22 / 125
    localparam int          DIV_SHIFT = 22;
    localparam longint      RECIP     = ((64'd1 << DIV_SHIFT) + LEVEL_MAX - 1) / LEVEL_MAX;
    localparam logic [31:0] WIDTH_MUL = 32'(FULL_WIDTH * RECIP);

    // drum groups
    typedef enum logic [1:0] {
        GRP_KICK_SNARE = 2'd0,
        GRP_TOM_CRASH  = 2'd1,
        GRP_HAT_RIDE   = 2'd2,
        GRP_NONE       = 2'd3
    } drum_group_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } scan_state_t;

    // note-on / frame tick
    localparam logic MODE_NOTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    function automatic drum_group_t group_of_pitch(input logic [6:0] p);
        drum_group_t g;
        unique case (p) inside
            7'd36, 7'd38, 7'd40:
                g = GRP_KICK_SNARE;
            7'd43, 7'd45, 7'd47, 7'd48, 7'd49, 7'd50, 7'd52, 7'd55, 7'd57, 7'd58:
                g = GRP_TOM_CRASH;
            7'd22, 7'd26, 7'd42, 7'd44, 7'd46, 7'd51, 7'd53, 7'd59:
                g = GRP_HAT_RIDE;
            default:
                g = GRP_NONE;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/drum_note_velocity_bar_meter_top.sv
// ----------------------------------------------------------------------------
// drum_note_velocity_bar_meter_top
// drum note velocity ring with per-frame bar output and level decay
// ----------------------------------------------------------------------------
// note-on words (mode 0) are filtered by drum group and, when passed, store
// their velocity in the next slot of a NUM_BARS-entry level memory and mark
// a redraw; a note-on gives no output. a frame tick (mode 1) with a redraw
// pending walks the memory from slot 0 up, giving one output word per slot
// (index, width = floor(FULL_WIDTH*level/127), last flag) and writing each
// level back decayed by 4 with a floor at 0. the walk is a read-modify-write
// on the single-port level memory with one read in flight at a time, and
// output stalls hold the walk. a tick with nothing pending starts no walk.
// no input word is taken during a walk. per-slot valid flops, cleared by
// reset, make the memory read as zero until a slot is written, so there is
// no clearing pass after reset. group_filter is to be written through
// cfg_we/cfg_wdata while idle; the block itself does not enforce this.
`default_nettype none

module drum_note_velocity_bar_meter_top
    import dnvb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // input words
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [6:0]         pitch,
    input  wire logic [LEVEL_W-1:0] velocity,

    // output words
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [IDX_W-1:0]        bar_index,
    output logic [WIDTH_W-1:0]      bar_width,
    output logic                    last_bar,

    // group filter register
    input  wire logic               cfg_we,
    input  wire logic [GROUP_W-1:0] cfg_wdata
);

    // level memory and per-slot written flags
    logic [LEVEL_W-1:0] level_mem [NUM_BARS];
    logic [NUM_BARS-1:0] written_reg;

    // control state
    scan_state_t        state_reg, state_next;
    logic [GROUP_W-1:0] filter_reg;
    logic [IDX_W-1:0]   write_slot_reg, write_slot_next;
    logic               pending_reg, pending_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               issue_done_reg, issue_done_next;

    // read stage
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [LEVEL_W-1:0] rd_level_reg;
    logic               rd_hit_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [WIDTH_W-1:0] out_width_reg;
    logic               out_last_reg;

    logic               in_fire, note_fire, tick_fire, note_pass;
    drum_group_t        note_group;
    logic               issue;
    logic [LEVEL_W-1:0] cur_level, decayed;
    logic               level_alive;
    logic [31:0]        width_prod;
    logic [WIDTH_W-1:0] width_val;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [LEVEL_W-1:0] mem_wdata;

    // ---------------------------------------------------------------- input

    assign in_fire    = in_valid && in_ready;
    assign note_group = group_of_pitch(pitch);
    assign note_pass  = (filter_reg == PASS_ALL)
                     || ((note_group != GRP_NONE) && (filter_reg == GROUP_W'(note_group)));
    assign note_fire  = in_fire && (mode == MODE_NOTE) && note_pass;
    assign tick_fire  = in_fire && (mode == MODE_TICK);

    assign write_slot_next = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;

    // ------------------------------------------------------------ fsm

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_fire && pending_reg)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // stay until the last read has been written back
                if (rd_vld_reg && (rd_idx_reg == LAST_SLOT))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_SCAN:
                // one read in flight; its data lands on a free output register
                issue = !issue_done_reg && !rd_vld_reg && (!out_valid_reg || out_ready);
            default:
            begin
                in_ready = 1'b0;
                issue    = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------- scan counter

    always_comb
    begin
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        if (tick_fire && pending_reg)
        begin
            scan_idx_next   = '0;
            issue_done_next = 1'b0;
        end
        else if (issue)
        begin
            if (scan_idx_reg == LAST_SLOT)
                issue_done_next = 1'b1;
            else
                scan_idx_next = scan_idx_reg + 1'b1;
        end
    end

    // ------------------------------------------------- level and bar math

    assign cur_level   = rd_hit_reg ? rd_level_reg : '0;
    assign level_alive = (cur_level >= DECAY_STEP);
    assign decayed     = level_alive ? (cur_level - DECAY_STEP) : '0;
    assign width_prod  = 32'(cur_level) * WIDTH_MUL;
    assign width_val   = WIDTH_W'(width_prod >> DIV_SHIFT);

    // redraw flag: set by a passed note or a surviving level, cleared by the tick
    always_comb
    begin
        pending_next = pending_reg;
        if (note_fire)
            pending_next = 1'b1;
        else if (tick_fire)
            pending_next = 1'b0;
        else if (rd_vld_reg && level_alive)
            pending_next = 1'b1;
    end

    // note writes happen only in idle, write-backs only during a walk
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = write_slot_next;
        mem_wdata = velocity;
        if (note_fire)
        begin
            mem_we    = 1'b1;
            mem_waddr = write_slot_next;
            mem_wdata = velocity;
        end
        else if (rd_vld_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_reg;
            mem_wdata = decayed;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rd_vld_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // -------------------------------------------------------------- memory

    always_ff @(posedge clk)
    begin
        if (mem_we)
            level_mem[mem_waddr] <= mem_wdata;
        if (issue)
            rd_level_reg <= level_mem[scan_idx_reg];
    end

    // ------------------------------------------------------------ registers

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            filter_reg     <= PASS_ALL;
            write_slot_reg <= LAST_SLOT;
            pending_reg    <= 1'b0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            written_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= issue;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
                filter_reg <= cfg_wdata;
            if (note_fire)
                write_slot_reg <= write_slot_next;
            if (mem_we)
                written_reg[mem_waddr] <= 1'b1;
        end
    end

    // read stage and output payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg <= scan_idx_reg;
            rd_hit_reg <= written_reg[scan_idx_reg];
        end
        if (rd_vld_reg)
        begin
            out_idx_reg   <= rd_idx_reg;
            out_width_reg <= width_val;
            out_last_reg  <= (rd_idx_reg == LAST_SLOT);
        end
    end

    assign out_valid = out_valid_reg;
    assign bar_index = out_idx_reg;
    assign bar_width = out_width_reg;
    assign last_bar  = out_last_reg;

    // ----------------------------------------------------------- assertions

`include "drum_note_velocity_bar_meter_top_assert.svh"

    `DNVB_ASSERT_IMPLY(a_land_free, clk, rst_n, rd_vld_reg, (!out_valid_reg || out_ready), "read data lands on a busy output word")
    `DNVB_ASSERT_IMPLY(a_no_wr_clash, clk, rst_n, in_ready, !rd_vld_reg, "write-back while input words are taken")
    `DNVB_ASSERT_NEXT(a_read_order, clk, rst_n, issue, (rd_vld_reg && (rd_idx_reg == $past(scan_idx_reg))), "read stage lost its slot index")

endmodule

`default_nettype wire
